@@ hw/rtl/serial_rtc_gpio_interface_top_macros.svh @@
// Assertion macros shared by the serial RTC GPIO interface checkers
`ifndef SERIAL_RTC_GPIO_INTERFACE_TOP_MACROS_SVH
`define SERIAL_RTC_GPIO_INTERFACE_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SRGI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define SRGI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/srgi_pkg.sv @@
// Shared types, constants and BCD conversion for the serial RTC GPIO interface
package srgi_pkg;

  typedef logic [7:0] byte_t;

  localparam int BufferBytes = 7;

  localparam byte_t OfsData    = 8'hC4;
  localparam byte_t OfsDir     = 8'hC6;
  localparam byte_t OfsCtrl    = 8'hC8;
  localparam byte_t StatusByte = 8'h40;

  localparam logic [2:0] CmdStatus      = 3'd1;
  localparam logic [2:0] CmdDateTime    = 3'd2;
  localparam logic [2:0] CmdDateTimeAlt = 3'd3;
  localparam logic [2:0] CmdTime        = 3'd4;

  localparam logic [2:0] LenStatus   = 3'd1;
  localparam logic [2:0] LenDateTime = 3'd7;
  localparam logic [2:0] LenTime     = 3'd3;

  function automatic byte_t bcd8(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rest;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    rest = v - 7'(7'(tens) * 7'd10);
    return {tens, rest[3:0]};
  endfunction

endpackage

@@ hw/rtl/serial_rtc_gpio_interface_top.sv @@
// Serial RTC behind data, direction and control byte registers
//
// Usage: each beat on the input channel (in_valid / in_stall) is one bus
// access: func selects read or write, reg_offset picks the data (0xC4),
// direction (0xC6) or control (0xC8) register. The date and time fields
// are sampled on the beat that completes a read command.
// Each input beat yields exactly one output beat (out_valid / out_stall)
// carrying rdata: the register on a read, zero on writes and unknown
// offsets.
// The output beat follows in the cycle after its input beat while the output
// is free. Throughput: one access per cycle while in_stall is low; the serial
// protocol state and registers update in the same cycle as the access.
// The output register is backed by one skid entry: an access is taken
// while a result waits; in_stall rises only once both hold results and
// out_stall is held high.
// Reset (rst, synchronous): the data, direction and control registers and protocol
// state clear to idle, both result stages empty; the byte buffer and result data hold no reset value.
module serial_rtc_gpio_interface_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  srgi_pkg::byte_t   reg_offset,
  input  srgi_pkg::byte_t   wdata,
  input  logic [6:0]        year_in_century,
  input  logic [3:0]        month,
  input  logic [4:0]        day_of_month,
  input  logic [2:0]        weekday,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [5:0]        second,
  output logic              out_valid,
  input  logic              out_stall,
  output srgi_pkg::byte_t   rdata
);
  import srgi_pkg::*;

  localparam logic [1:0] PsIdle    = 2'd0;
  localparam logic [1:0] PsCommand = 2'd1;
  localparam logic [1:0] PsReading = 2'd2;
  localparam logic [1:0] PsWriting = 2'd3;

  byte_t      pin_data, pin_data_next;
  byte_t      pin_direction, pin_direction_next;
  byte_t      pin_control, pin_control_next;
  logic [1:0] proto_state, proto_state_next;
  logic [5:0] bit_counter, bit_counter_next;
  byte_t      command_shift, command_shift_next;
  byte_t      serial_buffer [BufferBytes];
  byte_t      serial_buffer_next [BufferBytes];
  logic [2:0] byte_index, byte_index_next;
  logic [2:0] transfer_length, transfer_length_next;
  logic       chip_select_prev, chip_select_prev_next;
  logic       serial_clock_prev, serial_clock_prev_next;

  byte_t      skid_rdata;
  logic       skid_valid;
  byte_t      result;
  logic       accept;
  logic       take;

  logic       cs, sck, sio;
  byte_t      shifted;
  logic [5:0] count_inc;
  logic [2:0] cmd_code;
  logic       cmd_read;
  logic       cmd_ok;
  logic [2:0] cmd_len;
  logic       out_bit;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  assign cs       = wdata[2];
  assign sck      = wdata[0];
  assign sio      = wdata[1];
  assign cmd_code = {shifted[4], shifted[5], shifted[6]};
  assign cmd_read = shifted[7];

  always_comb begin
    unique case (cmd_code)
      CmdStatus: begin
        cmd_ok  = 1'b1;
        cmd_len = LenStatus;
      end
      CmdDateTime, CmdDateTimeAlt: begin
        cmd_ok  = 1'b1;
        cmd_len = LenDateTime;
      end
      CmdTime: begin
        cmd_ok  = 1'b1;
        cmd_len = LenTime;
      end
      default: begin
        cmd_ok  = 1'b0;
        cmd_len = 3'd0;
      end
    endcase
  end

  always_comb begin
    pin_data_next          = pin_data;
    pin_direction_next     = pin_direction;
    pin_control_next       = pin_control;
    proto_state_next       = proto_state;
    bit_counter_next       = bit_counter;
    command_shift_next     = command_shift;
    byte_index_next        = byte_index;
    transfer_length_next   = transfer_length;
    chip_select_prev_next  = chip_select_prev;
    serial_clock_prev_next = serial_clock_prev;
    serial_buffer_next     = serial_buffer;
    result                 = '0;
    shifted                = command_shift;
    count_inc              = bit_counter + 6'd1;
    out_bit                = 1'b0;

    if (accept && func) begin
      if (reg_offset == OfsData) begin
        pin_data_next = wdata;
        if (cs && !chip_select_prev) begin
          proto_state_next   = PsCommand;
          bit_counter_next   = '0;
          command_shift_next = '0;
          byte_index_next    = '0;
        end
        if (!cs) begin
          proto_state_next = PsIdle;
        end
        shifted   = command_shift_next | byte_t'({7'd0, sio} << bit_counter_next[2:0]);
        count_inc = bit_counter_next + 6'd1;
        if (cs && sck && !serial_clock_prev) begin
          if (pin_direction[1]) begin
            if (proto_state_next == PsCommand) begin
              command_shift_next = shifted;
              bit_counter_next   = count_inc;
              if (count_inc == 6'd8) begin
                bit_counter_next = '0;
                if (cmd_ok) begin
                  transfer_length_next = cmd_len;
                  for (int i = 0; i < BufferBytes; i++) begin
                    if (3'(i) < cmd_len) begin
                      serial_buffer_next[i] = '0;
                    end
                  end
                  if (cmd_read) begin
                    priority if (cmd_code == CmdStatus) begin
                      serial_buffer_next[0] = StatusByte;
                    end else if (cmd_code == CmdTime) begin
                      serial_buffer_next[0] = bcd8({2'd0, hour});
                      serial_buffer_next[1] = bcd8({1'd0, minute});
                      serial_buffer_next[2] = bcd8({1'd0, second});
                    end else begin
                      serial_buffer_next[0] = bcd8(year_in_century);
                      serial_buffer_next[1] = bcd8({3'd0, month});
                      serial_buffer_next[2] = bcd8({2'd0, day_of_month});
                      serial_buffer_next[3] = bcd8({4'd0, weekday});
                      serial_buffer_next[4] = bcd8({2'd0, hour});
                      serial_buffer_next[5] = bcd8({1'd0, minute});
                      serial_buffer_next[6] = bcd8({1'd0, second});
                    end
                    proto_state_next = PsReading;
                  end else begin
                    proto_state_next = PsWriting;
                  end
                end else begin
                  proto_state_next = PsIdle;
                end
              end
            end else if (proto_state_next == PsWriting &&
                         byte_index_next < transfer_length_next) begin
              if ({1'b0, byte_index_next} < 4'(BufferBytes)) begin
                serial_buffer_next[byte_index_next][bit_counter_next[2:0]] =
                  serial_buffer[byte_index_next][bit_counter_next[2:0]] | sio;
              end
              bit_counter_next = count_inc;
              if (count_inc[2:0] == 3'd0) begin
                byte_index_next = byte_index_next + 3'd1;
              end
            end
          end else if (proto_state_next == PsReading &&
                       byte_index_next < transfer_length_next) begin
            if ({1'b0, byte_index_next} < 4'(BufferBytes)) begin
              out_bit = serial_buffer[byte_index_next][bit_counter_next[2:0]];
            end
            pin_data_next[1] = out_bit;
            bit_counter_next = count_inc;
            if (count_inc[2:0] == 3'd0) begin
              byte_index_next = byte_index_next + 3'd1;
            end
          end
        end
        chip_select_prev_next  = cs;
        serial_clock_prev_next = sck;
      end else if (reg_offset == OfsDir) begin
        pin_direction_next = wdata;
      end else if (reg_offset == OfsCtrl) begin
        pin_control_next = wdata;
      end
    end else if (accept) begin
      if (reg_offset == OfsData) begin
        result = pin_data;
      end else if (reg_offset == OfsDir) begin
        result = pin_direction;
      end else if (reg_offset == OfsCtrl) begin
        result = pin_control;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_data          <= '0;
      pin_direction     <= '0;
      pin_control       <= '0;
      proto_state       <= PsIdle;
      bit_counter       <= '0;
      command_shift     <= '0;
      byte_index        <= '0;
      transfer_length   <= '0;
      chip_select_prev  <= 1'b0;
      serial_clock_prev <= 1'b0;
    end else begin
      pin_data          <= pin_data_next;
      pin_direction     <= pin_direction_next;
      pin_control       <= pin_control_next;
      proto_state       <= proto_state_next;
      bit_counter       <= bit_counter_next;
      command_shift     <= command_shift_next;
      byte_index        <= byte_index_next;
      transfer_length   <= transfer_length_next;
      chip_select_prev  <= chip_select_prev_next;
      serial_clock_prev <= serial_clock_prev_next;
    end
  end

  always_ff @(posedge clk) begin
    serial_buffer <= serial_buffer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (take && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (accept && (!out_valid || take)) begin
        out_valid <= 1'b1;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      rdata <= skid_rdata;
    end else if (accept && (!out_valid || take)) begin
      rdata <= result;
    end
    if (accept && out_valid && !take) begin
      skid_rdata <= result;
    end
  end

endmodule

@@ hw/rtl/srgi_checker.sv @@
// Port-level checker for the serial RTC GPIO interface, bound to the top level
`include "serial_rtc_gpio_interface_top_macros.svh"

module srgi_port_assertions (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            func,
  input srgi_pkg::byte_t rdata,
  input logic            out_valid,
  input logic            out_stall
);

  // hold a stalled result
  `SRGI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(rdata), "stalled result changed")

  // deliver a beat in the cycle after acceptance into a free output; writes return zero
  `SRGI_ASSERT_NEXT(a_write_zero, clk, rst, in_valid && !in_stall && func && (!out_valid || !out_stall), out_valid && rdata == 8'd0, "write beat did not return zero next cycle")

  // stall input only after the output was stalled
  `SRGI_ASSERT_NOW(a_stall_cause, clk, rst, $rose(in_stall), $past(out_valid && out_stall), "input stall without output stall")

  // never hold a skid entry behind an empty output
  `SRGI_ASSERT_NOW(a_skid_order, clk, rst, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind serial_rtc_gpio_interface_top srgi_port_assertions u_srgi_port_assertions (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .rdata     (rdata),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
